@@ hdl/afrc_pkg.sv @@
// ----------------------------------------------------------------------------
// afrc_pkg
// Shared types and constants of the frame receiver with additive checksum.
// ----------------------------------------------------------------------------
package afrc_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;

  // Closing status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_MAX_FRAME  = 1'b1;

  localparam logic [7:0]  CSUM_BASE    = 8'hFF;
  localparam logic [16:0] HDR_OVERHEAD = 17'd4;

  // One result item
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
  } afrc_res_t;

endpackage

@@ hdl/afrc_parser.sv @@
// ----------------------------------------------------------------------------
// afrc_parser
// Frame parse state and per-byte result logic; state advances on each fire.
// ----------------------------------------------------------------------------
module afrc_parser
  import afrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  start_byte,
  input  logic [16:0] max_frame_bytes,
  output logic        res_valid,
  output afrc_res_t   res
);

  logic [2:0]  phase_r,    phase_nxt;
  logic [7:0]  len_hi_r,   len_hi_nxt;
  logic [15:0] data_len_r, data_len_nxt;
  logic [15:0] seen_r,     seen_nxt;
  logic [7:0]  sum_r,      sum_nxt;
  logic        over_r,     over_nxt;
  logic [15:0] new_len;
  logic [15:0] seen_inc;

  assign new_len  = {len_hi_r, rx_byte};
  assign seen_inc = seen_r + 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    len_hi_nxt   = len_hi_r;
    data_len_nxt = data_len_r;
    seen_nxt     = seen_r;
    sum_nxt      = sum_r;
    over_nxt     = over_r;
    res_valid    = 1'b0;
    res          = '0;
    res.frame_length = data_len_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == start_byte) phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_hi_nxt = rx_byte;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        data_len_nxt = new_len;
        seen_nxt     = '0;
        sum_nxt      = '0;
        over_nxt     = ({1'b0, new_len} + HDR_OVERHEAD) > max_frame_bytes;
        phase_nxt    = (new_len == 16'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        sum_nxt           = sum_r + rx_byte;
        res_valid         = !over_r;
        res.payload_byte  = rx_byte;
        res.payload_index = seen_r;
        seen_nxt          = seen_inc;
        if (seen_inc >= data_len_r) phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        res_valid      = 1'b1;
        res.frame_done = 1'b1;
        if (over_r) begin
          res.frame_status = ST_TOO_BIG;
        end else if ((CSUM_BASE - sum_r) == rx_byte) begin
          res.frame_status = ST_OK;
        end else begin
          res.frame_status = ST_CSUM_ERR;
        end
        phase_nxt = PH_HUNT;
        over_nxt  = 1'b0;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      len_hi_r   <= '0;
      data_len_r <= '0;
      seen_r     <= '0;
      sum_r      <= '0;
      over_r     <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      len_hi_r   <= len_hi_nxt;
      data_len_r <= data_len_nxt;
      seen_r     <= seen_nxt;
      sum_r      <= sum_nxt;
      over_r     <= over_nxt;
    end
  end

  ap_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> seen_r < data_len_r)
    else $error("data phase with all bytes already seen");

  ap_over_only_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT |-> !over_r)
    else $error("oversize flag set while hunting");

  ap_data_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> data_len_r != 16'd0)
    else $error("data phase entered with zero length");

endmodule

@@ hdl/api_frame_receiver_checksum_core.sv @@
// ----------------------------------------------------------------------------
// api_frame_receiver_checksum_core
// Byte-stream frame receiver: start byte, 16-bit length, data, checksum.
// ----------------------------------------------------------------------------
//  channel | direction | transfer when            | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | sink      | in_valid && !in_stall    | in_rx_byte
//  out     | source    | out_valid && !out_stall  | payload byte/index, done,
//          |           |                          | status, length
//  cfg     | sink      | cfg_we                   | cfg_index, cfg_data
//
//  One byte per cycle while the output is not stalled: a byte is held in the
//  input register, the parser updates its state and forms the result from it
//  combinationally, and the result lands in the output register, which drives
//  out_valid; the result thus passes the input and output registers in turn.
//  Bytes that give no result retire even while the output is stalled; a
//  byte with a result waits in the input register until the output frees.
//  Reset (synchronous, active low) empties both registers, returns to the
//  start-byte hunt and loads start_byte = 0x7E, max_frame_bytes = 256.
// ----------------------------------------------------------------------------
module api_frame_receiver_checksum_core
  import afrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_frame_length,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  logic [7:0]  start_byte_r;
  logic [16:0] max_frame_r;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r;
  afrc_res_t   out_res_r;

  logic        res_valid;
  afrc_res_t   res;
  logic        out_free;
  logic        fire;
  logic        in_take;

  // Output register can take a new result when empty or draining this cycle
  assign out_free = !out_vld_r || !out_stall;
  // Retire the held byte unless it has a result and the output is blocked
  assign fire     = in_vld_r && (!res_valid || out_free);
  assign in_stall = in_vld_r && !fire;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'h7E;
      max_frame_r  <= 17'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_data[7:0];
        CFG_MAX_FRAME:  max_frame_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refill when empty or when the held byte retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_byte_r <= in_rx_byte;
  end

  afrc_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .rx_byte         (in_byte_r),
    .start_byte      (start_byte_r),
    .max_frame_bytes (max_frame_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register: load on a retiring byte with a result, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) out_res_r <= res;
  end

  assign out_valid         = out_vld_r;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_index = out_res_r.payload_index;
  assign out_frame_done    = out_res_r.frame_done;
  assign out_frame_status  = out_res_r.frame_status;
  assign out_frame_length  = out_res_r.frame_length;

  ap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |-> out_free)
    else $error("result loaded over a stalled result");

  ap_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.frame_done |->
      out_res_r.payload_byte == 8'd0 && out_res_r.payload_index == 16'd0)
    else $error("status result carries data fields");

  ap_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.frame_done |-> out_res_r.frame_status == ST_OK)
    else $error("data result carries a status");

  ap_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("registers not empty after reset");

endmodule
